// ===== hdl/fpu_pkg.sv =====
// ---------------------------------------------------------------------------
// fpu_pkg
// Shared types and constants of the binary32 add/sub/mul/div unit.
// ---------------------------------------------------------------------------
`default_nettype none

package fpu_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SETUP = 3'd1,
    ST_ITER  = 3'd2,
    ST_NORM  = 3'd3,
    ST_ROUND = 3'd4,
    ST_OUT   = 3'd5
  } state_t;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF  = 32'h7F80_0000;
  localparam int          DIV_BITS = 29;
  localparam int          WIDE     = 56;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic setup;
    logic iter;
    logic norm;
    logic round;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic special;
    logic is_div;
    logic iter_done;
    logic norm_done;
  } dp_sts_t;

endpackage : fpu_pkg

`default_nettype wire

// ===== hdl/fpu_if.sv =====
// ---------------------------------------------------------------------------
// fpu_req_if / fpu_rsp_if
// Valid/ready channels carrying request and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface fpu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface : fpu_req_if

interface fpu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface : fpu_rsp_if

`default_nettype wire

// ===== hdl/fp32_add_sub_mul_div_unit.sv =====
// ---------------------------------------------------------------------------
// fp32_add_sub_mul_div_unit
// Binary32 add, subtract, multiply and divide, round to nearest even, FTZ.
// ---------------------------------------------------------------------------
// One request beat at a time. Add and subtract pass through idle, setup,
// normalise in steps of up to eight bits, round and result (the long case is
// deep cancellation); multiply follows the same path, and special operands or
// exact cancellation go from setup straight to the result. Divide runs a
// restoring loop, one quotient bit a cycle for 29 bits, then normalises and
// rounds. The result is held until the result beat is taken, then the next
// request is accepted.
`default_nettype none

module fp32_add_sub_mul_div_unit import fpu_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  fpu_req_if.sink   in_ch,
  fpu_rsp_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  fpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic
  fpu_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (in_ch.req_type),
    .operand_a   (in_ch.operand_a),
    .operand_b   (in_ch.operand_b),
    .result_bits (out_ch.result_bits)
  );

  // a request is never accepted while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("accept during result");

  // result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_bits))
    else $error("result dropped");

  // a taken result frees the input
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |=> in_ch.ready) else $error("no return to idle");

endmodule : fp32_add_sub_mul_div_unit

`default_nettype wire

// ===== hdl/fpu_ctrl.sv =====
// ---------------------------------------------------------------------------
// fpu_ctrl
// Sequencer: load, setup, divide iterations, normalise, round, result.
// ---------------------------------------------------------------------------
`default_nettype none

module fpu_ctrl import fpu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.special)     state_nxt = ST_OUT;
        else if (sts.is_div) state_nxt = ST_ITER;
        else                 state_nxt = ST_NORM;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_done) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
        if (sts.norm_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule : fpu_ctrl

`default_nettype wire

// ===== hdl/fpu_dp.sv =====
// ---------------------------------------------------------------------------
// fpu_dp
// Datapath: decode, special cases, align/add, multiply, restoring divide,
// normalise in steps of up to eight bits, round and encode.
// ---------------------------------------------------------------------------
`default_nettype none

module fpu_dp import fpu_pkg::*; (
  input  wire logic        clk,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic [31:0]      result_bits
);

  logic [1:0]  op_r;
  logic [31:0] a_r, b_r;
  logic [31:0] res_r, res_nxt;
  logic        special_r;
  logic        sign_r;
  logic signed [10:0] exp_r;
  logic [WIDE-1:0] w_r;
  logic [4:0]  lane_r;
  logic [24:0] rem_r;
  logic [23:0] den_r;
  logic [4:0]  cnt_r;

  // operand fields
  logic        sa, sb, sbe;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        za, zb, ia, ib, na, nb;
  always_comb begin
    sa  = a_r[31];
    sb  = b_r[31];
    sbe = b_r[31] ^ (op_r == OP_SUB);
    ea  = a_r[30:23];
    eb  = b_r[30:23];
    ma  = {1'b1, a_r[22:0]};
    mb  = {1'b1, b_r[22:0]};
    za  = (ea == 8'd0);
    zb  = (eb == 8'd0);
    ia  = (ea == 8'hFF) && (a_r[22:0] == 23'd0);
    ib  = (eb == 8'hFF) && (b_r[22:0] == 23'd0);
    na  = (ea == 8'hFF) && (a_r[22:0] != 23'd0);
    nb  = (eb == 8'hFF) && (b_r[22:0] != 23'd0);
  end

  // special case detection
  logic        spec;
  logic [31:0] spec_val;
  logic        sx;
  always_comb begin
    sx       = sa ^ sb;
    spec     = 1'b1;
    spec_val = QNAN;
    if (na || nb) begin
      spec_val = QNAN;
    end else if (op_r == OP_ADD || op_r == OP_SUB) begin
      if (ia && ib)    spec_val = (sa != sbe) ? QNAN : (POS_INF | {sa, 31'd0});
      else if (ia)     spec_val = POS_INF | {sa, 31'd0};
      else if (ib)     spec_val = POS_INF | {sbe, 31'd0};
      else if (za && zb) spec_val = {sa & sbe, 31'd0};
      else if (za)     spec_val = {sbe, b_r[30:0]};
      else if (zb)     spec_val = a_r;
      else             spec = 1'b0;
    end else if (op_r == OP_MUL) begin
      if ((ia && zb) || (za && ib)) spec_val = QNAN;
      else if (ia || ib)            spec_val = POS_INF | {sx, 31'd0};
      else if (za || zb)            spec_val = {sx, 31'd0};
      else                          spec = 1'b0;
    end else begin
      if ((ia && ib) || (za && zb)) spec_val = QNAN;
      else if (ia || zb)            spec_val = POS_INF | {sx, 31'd0};
      else if (za || ib)            spec_val = {sx, 31'd0};
      else                          spec = 1'b0;
    end
  end

  // add alignment
  logic        swp;
  logic [7:0]  e_big, diff;
  logic [23:0] m_big, m_sml;
  logic        s_big, s_sml;
  logic [WIDE-1:0] big_w, sml_w, sml_sh, add_res;
  logic        sticky, cancel;
  logic        add_sign;
  always_comb begin
    swp   = (eb > ea);
    e_big = swp ? eb : ea;
    diff  = swp ? (eb - ea) : (ea - eb);
    m_big = swp ? mb : ma;
    m_sml = swp ? ma : mb;
    s_big = swp ? sbe : sa;
    s_sml = swp ? sa : sbe;
    big_w = {8'd0, m_big, 24'd0};
    sml_w = {8'd0, m_sml, 24'd0};
    if (diff >= 8'd48) begin
      sml_sh = '0;
      sticky = 1'b1;
    end else begin
      sml_sh = sml_w >> diff;
      sticky = ((sml_sh << diff) != sml_w);
    end
    sml_sh[0] = sml_sh[0] | sticky;
    add_sign  = s_big;
    cancel    = 1'b0;
    if (s_big == s_sml) begin
      add_res = big_w + sml_sh;
    end else if (big_w >= sml_sh) begin
      add_res = big_w - sml_sh;
      cancel  = (add_res == '0);
    end else begin
      add_res  = sml_sh - big_w;
      add_sign = s_sml;
    end
  end

  // mantissa product
  logic [47:0] prod;
  assign prod = ma * mb;

  // normalise: top bit at 23+lane, done in steps of up to 8
  logic [5:0]  top;
  logic        hi, lo;
  logic [WIDE-1:0] w_norm;
  logic signed [10:0] exp_norm;
  always_comb begin
    top      = 6'd23 + {1'b0, lane_r};
    hi       = ((w_r >> (top + 6'd1)) != '0);
    lo       = ((w_r >> top) == '0);
    w_norm   = w_r;
    exp_norm = exp_r;
    if (hi) begin
      w_norm   = (w_r >> 1) | {{(WIDE-1){1'b0}}, w_r[0]};
      exp_norm = exp_r + 11'sd1;
    end else if (lo) begin
      if ((w_r >> (top - 6'd8)) == '0) begin
        w_norm   = w_r << 8;
        exp_norm = exp_r - 11'sd8;
      end else begin
        w_norm   = w_r << 1;
        exp_norm = exp_r - 11'sd1;
      end
    end
  end

  // rounding and encode
  logic [WIDE-1:0] rmask;
  logic        rbit, sbit;
  logic [24:0] m_rnd;
  logic signed [10:0] e_rnd, biased;
  always_comb begin
    rmask  = {{(WIDE-1){1'b0}}, 1'b1} << (lane_r - 5'd1);
    rbit   = ((w_r & rmask) != '0);
    sbit   = ((w_r & (rmask - 1'b1)) != '0);
    m_rnd  = 25'(w_r >> lane_r);
    e_rnd  = exp_r;
    if (rbit && (sbit || m_rnd[0])) begin
      m_rnd = m_rnd + 25'd1;
      if (m_rnd[24]) begin
        m_rnd = m_rnd >> 1;
        e_rnd = exp_r + 11'sd1;
      end
    end
    biased = e_rnd + 11'sd127;
    if (biased >= 11'sd255)   res_nxt = POS_INF | {sign_r, 31'd0};
    else if (biased <= 11'sd0) res_nxt = {sign_r, 31'd0};
    else res_nxt = {sign_r, biased[7:0], m_rnd[22:0]};
  end

  // divide step: restoring, one quotient bit a cycle
  logic [25:0] trial;
  assign trial = {rem_r, 1'b0} - {2'b0, den_r};

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= req_type;
      a_r  <= operand_a;
      b_r  <= operand_b;
    end
    if (cmd.setup) begin
      // exact cancellation leaves a plain +0
      special_r <= sts.special;
      res_r     <= spec ? spec_val : 32'd0;
      cnt_r     <= '0;
      unique case (op_r)
        OP_MUL: begin
          sign_r <= sx;
          exp_r  <= 11'(ea) + 11'(eb) - 11'sd254;
          w_r    <= WIDE'(prod);
          lane_r <= 5'd23;
        end
        OP_DIV: begin
          sign_r <= sx;
          exp_r  <= 11'(ea) - 11'(eb);
          w_r    <= '0;
          lane_r <= 5'd5;
          rem_r  <= {1'b0, ma};
          den_r  <= mb;
        end
        default: begin
          sign_r <= add_sign;
          exp_r  <= 11'(e_big) - 11'sd127;
          w_r    <= add_res;
          lane_r <= 5'd24;
        end
      endcase
    end
    if (cmd.iter) begin
      // quotient of ma*2^28/mb: first bit from rem, then 28 shifts
      if (cnt_r == 5'd0) begin
        if (rem_r >= {1'b0, den_r}) begin
          w_r   <= WIDE'(1);
          rem_r <= rem_r - {1'b0, den_r};
        end
      end else if (!trial[25]) begin
        w_r   <= {w_r[WIDE-2:0], 1'b1};
        rem_r <= trial[24:0];
      end else begin
        w_r   <= {w_r[WIDE-2:0], 1'b0};
        rem_r <= {rem_r[23:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.norm) begin
      if (cnt_r == 5'(DIV_BITS) && rem_r != '0) begin
        w_r <= w_norm | WIDE'(1);
      end else begin
        w_r <= w_norm;
      end
      cnt_r    <= '0;
      exp_r    <= exp_norm;
    end
    if (cmd.round) res_r <= res_nxt;
  end

  assign sts.special   = spec || (op_r != OP_MUL && op_r != OP_DIV && cancel);
  assign sts.is_div    = (op_r == OP_DIV);
  assign sts.iter_done = (cnt_r == 5'(DIV_BITS - 1));
  assign sts.norm_done = !hi && !lo && !(cnt_r == 5'(DIV_BITS));
  assign result_bits   = special_r ? res_r : res_r;

endmodule : fpu_dp

`default_nettype wire

// ===== verif/fp32_add_sub_mul_div_unit_tb.sv =====
// ---------------------------------------------------------------------------
// fp32_add_sub_mul_div_unit_tb
// Checks every result beat of the binary32 unit against a bit-exact software
// model (round to nearest even, flush to zero, canonical NaN), with random
// idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module fp32_add_sub_mul_div_unit_tb import fpu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  localparam int N_RANDOM = 930;

  logic clk;
  logic rst_n;
  fpu_req_if in_ch ();
  fpu_rsp_if out_ch ();

  fp_req_t     pending_reqs[$];
  logic [31:0] expected_results[$];
  int          n_errors;
  int          n_results;
  int          n_sent;
  int          op_count[4];
  bit          calm;

  fp32_add_sub_mul_div_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // operand classes and packing
  function automatic logic [31:0] fp_pack(bit s, int e, logic [22:0] m);
    fp_pack = {s, e[7:0], m};
  endfunction

  function automatic bit fp_is_nan(logic [31:0] x);
    fp_is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic bit fp_is_inf(logic [31:0] x);
    fp_is_inf = (x[30:23] == 8'hFF) && (x[22:0] == 0);
  endfunction

  function automatic bit fp_is_zero(logic [31:0] x);
    fp_is_zero = (x[30:23] == 8'h00);
  endfunction

  // normalise, round to nearest even and encode with flush to zero
  function automatic logic [31:0] fp_round(bit s, int e, logic [63:0] w, int lane);
    int          top;
    int          g;
    int          biased;
    bit          rbit;
    bit          sbit;
    logic [63:0] m;
    top = 23 + lane;
    g = 64;
    if (w == 0) return {s, 31'd0};
    while ((w >> top) == 0 && g > 0) begin
      w = w << 1;
      e--;
      g--;
    end
    while ((w >> (top + 1)) != 0) begin
      w = (w >> 1) | (w & 64'd1);
      e++;
    end
    rbit = w[lane-1];
    sbit = (w & ((64'd1 << (lane - 1)) - 1)) != 0;
    m = w >> lane;
    if (rbit && (sbit || m[0])) begin
      m++;
      if (m == 64'h100_0000) begin
        m = m >> 1;
        e++;
      end
    end
    biased = e + 127;
    if (biased >= 255) return {s, 31'h7F80_0000};
    if (biased <= 0) return {s, 31'd0};
    return {s, biased[7:0], m[22:0]};
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b, bit negate_b);
    bit          sa;
    bit          sb;
    bit          rs;
    bit          st;
    int          ea;
    int          eb;
    int          diff;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] rm;
    logic [31:0] t;
    sa = a[31];
    sb = b[31] ^ negate_b;
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
    if (fp_is_inf(a) && fp_is_inf(b)) return (sa != sb) ? QNAN : {sa, POS_INF[30:0]};
    if (fp_is_inf(a)) return {sa, POS_INF[30:0]};
    if (fp_is_inf(b)) return {sb, POS_INF[30:0]};
    if (fp_is_zero(a) && fp_is_zero(b)) return {sa & sb, 31'd0};
    if (fp_is_zero(a)) return {sb, b[30:0]};
    if (fp_is_zero(b)) return a;
    ea = int'(a[30:23]) - 127;
    eb = int'(b[30:23]) - 127;
    ma = {41'd1, a[22:0]} << 24;
    mb = {41'd1, b[22:0]} << 24;
    if (eb > ea) begin
      t = {sa, 31'd0}; sa = sb; sb = t[31];
      diff = ea; ea = eb; eb = diff;
      rm = ma; ma = mb; mb = rm;
    end
    diff = ea - eb;
    st = 1'b0;
    if (diff >= 56) begin
      st = mb != 0;
      mb = 0;
    end else if (diff > 0) begin
      st = (mb & ((64'd1 << diff) - 1)) != 0;
      mb = mb >> diff;
    end
    if (st) mb[0] = 1'b1;
    rs = sa;
    if (sa == sb) rm = ma + mb;
    else begin
      if (ma >= mb) rm = ma - mb;
      else begin
        rm = mb - ma;
        rs = sb;
      end
      if (rm == 0) return 32'd0;
    end
    return fp_round(rs, ea, rm, 24);
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    bit s;
    s = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
    if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) return QNAN;
    if (fp_is_inf(a) || fp_is_inf(b)) return {s, POS_INF[30:0]};
    if (fp_is_zero(a) || fp_is_zero(b)) return {s, 31'd0};
    return fp_round(s, int'(a[30:23]) + int'(b[30:23]) - 254,
                    {41'd1, a[22:0]} * {41'd1, b[22:0]}, 23);
  endfunction

  function automatic logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
    bit          s;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    s = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return QNAN;
    if (fp_is_inf(a) && fp_is_inf(b)) return QNAN;
    if (fp_is_zero(a) && fp_is_zero(b)) return QNAN;
    if (fp_is_inf(a) || fp_is_zero(b)) return {s, POS_INF[30:0]};
    if (fp_is_zero(a) || fp_is_inf(b)) return {s, 31'd0};
    num = {41'd1, a[22:0]} << 28;
    den = {41'd1, b[22:0]};
    q = num / den;
    if (num % den != 0) q[0] = 1'b1;
    return fp_round(s, int'(a[30:23]) - int'(b[30:23]), q, 5);
  endfunction

  function automatic logic [31:0] fp_result(fp_req_t r);
    case (r.op)
      OP_ADD: fp_result = fp_add(r.a, r.b, 1'b0);
      OP_SUB: fp_result = fp_add(r.a, r.b, 1'b1);
      OP_MUL: fp_result = fp_mul(r.a, r.b);
      default: fp_result = fp_div(r.a, r.b);
    endcase
  endfunction

  // random operand, biased towards special and boundary values
  function automatic logic [31:0] rand_operand();
    int          k;
    logic [22:0] m;
    k = $urandom_range(0, 99);
    m = 23'($urandom);
    if (k < 4) return {1'($urandom), 31'd0};
    if (k < 7) return {1'($urandom), 8'h00, m};
    if (k < 10) return {1'($urandom), 8'hFF, 23'd0};
    if (k < 12) return {1'($urandom), 8'hFF, (m == 0) ? 23'd1 : m};
    if (k < 20) return fp_pack(1'($urandom), $urandom_range(1, 12), m);
    if (k < 28) return fp_pack(1'($urandom), $urandom_range(240, 254), m);
    if (k < 60) return fp_pack(1'($urandom), $urandom_range(110, 145), m);
    return $urandom;
  endfunction

  task automatic queue_req(op_t op, logic [31:0] a, logic [31:0] b);
    fp_req_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    pending_reqs.push_back(r);
  endtask

  // stimulus
  initial begin
    fp_req_t     r;
    logic [31:0] a;
    n_errors = 0;
    n_results = 0;
    n_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    // directed: extremes and special cases
    queue_req(OP_ADD, 32'h7FC0_0001, 32'h3F80_0000);
    queue_req(OP_ADD, 32'h7F80_0000, 32'hFF80_0000);
    queue_req(OP_SUB, 32'h7F80_0000, 32'h7F80_0000);
    queue_req(OP_SUB, 32'hFF80_0000, 32'h3F80_0000);
    queue_req(OP_ADD, 32'h8000_0000, 32'h8000_0000);
    queue_req(OP_SUB, 32'h8000_0000, 32'h0000_0000);
    queue_req(OP_SUB, 32'h0000_0000, 32'h4040_0000);
    queue_req(OP_ADD, 32'h4040_0000, 32'h0000_0001);
    queue_req(OP_SUB, 32'h3F80_0001, 32'h3F80_0001);
    queue_req(OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    queue_req(OP_SUB, 32'h0080_0001, 32'h0080_0000);
    queue_req(OP_ADD, 32'h3F80_0000, 32'h3380_0000);
    queue_req(OP_ADD, 32'h7F7F_FFFF, 32'h0080_0000);
    queue_req(OP_MUL, 32'h7F80_0000, 32'h8000_0000);
    queue_req(OP_MUL, 32'hFF80_0000, 32'h4000_0000);
    queue_req(OP_MUL, 32'h8000_0000, 32'h4000_0000);
    queue_req(OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000);
    queue_req(OP_MUL, 32'h0080_0000, 32'h3F00_0000);
    queue_req(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(OP_DIV, 32'h0000_0000, 32'h8000_0000);
    queue_req(OP_DIV, 32'h7F80_0000, 32'hFF80_0000);
    queue_req(OP_DIV, 32'hFF80_0000, 32'h3F80_0000);
    queue_req(OP_DIV, 32'h3F80_0000, 32'h8000_0000);
    queue_req(OP_DIV, 32'h3F80_0000, 32'h7F80_0000);
    queue_req(OP_DIV, 32'h3F80_0000, 32'h4040_0000);
    // random: mostly structured operands, some cancellation pairs
    for (int i = 0; i < N_RANDOM; i++) begin
      r.op = op_t'($urandom_range(0, 3));
      r.a = rand_operand();
      r.b = rand_operand();
      if ($urandom_range(0, 9) == 0) begin
        a = r.a;
        r.b = {a[31] ^ (r.op == OP_ADD), a[30:2], 2'($urandom)};
      end
      pending_reqs.push_back(r);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d requests (add %0d, sub %0d, mul %0d, div %0d), %0d results",
             n_sent, op_count[0], op_count[1], op_count[2], op_count[3], n_results);
    $display("mismatches: %0d, results left over: %0d", n_errors, expected_results.size());
    if (n_errors == 0 && expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // quiet stretch with no idling on either side
  always @(posedge clk) begin
    if (n_sent == 300) calm <= 1'b1;
    else if (n_sent == 450) calm <= 1'b0;
  end

  // request driver
  always @(posedge clk) begin
    fp_req_t r;
    if (rst_n && (!in_ch.valid || in_ch.ready)) begin
      if (in_ch.valid) begin
        expected_results.push_back(fp_result('{op_t'(in_ch.req_type), in_ch.operand_a,
                                               in_ch.operand_b}));
        op_count[in_ch.req_type]++;
        n_sent++;
      end
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= r.op;
        in_ch.operand_a <= r.a;
        in_ch.operand_b <= r.b;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result beat %h", out_ch.result_bits);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_bits !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result mismatch: expected %h, got %h", want, out_ch.result_bits);
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule : fp32_add_sub_mul_div_unit_tb

`default_nettype wire
